[rtl/llwd_pkg.sv]
// Shared constants, result codes, controller states and the command/status
// structs of the least-loaded window dispatcher. Depends on nothing.
`default_nettype none
package llwd_pkg;

    localparam int QUEUE_DEPTH = 48;
    localparam int MAX_WINDOWS = 16;

    localparam int TIME_W   = 10;
    localparam int TICKET_W = 16;
    localparam int WINDOW_W = 4;
    localparam int LOAD_W   = 24;
    localparam int WCFG_W   = 5;

    // queue fill count holds 0..QUEUE_DEPTH, the address 0..QUEUE_DEPTH-1
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QADR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    // window counter holds 0..MAX_WINDOWS, the index 0..MAX_WINDOWS-1
    localparam int WCNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int WIDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    localparam int ENTRY_W = TIME_W + TICKET_W;

    localparam logic [LOAD_W-1:0]   LOAD_MAX   = '1;
    localparam logic [TICKET_W-1:0] TICKET_MAX = '1;

    localparam logic [WCFG_W-1:0] WCOUNT_RESET = WCFG_W'(4);

    typedef enum logic [1:0] {
        KIND_ISSUED = 2'd0,
        KIND_ASSIGN = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_FULL   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_ASSIGN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic enq;
        logic dist_start;
        logic fetch;
        logic scan_step;
        logic assign_tkt;
        logic report;
    } llwd_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_done;
        logic last_ticket;
        logic last_window;
    } llwd_status_t;

endpackage
`default_nettype wire

[rtl/least_loaded_window_dispatcher.sv]
// Top level of the least-loaded window dispatcher: APB register for the
// window count, controller and datapath. Uses llwd_pkg, llwd_ctrl, llwd_datapath.
// Enqueue: result beat in the cycle after accept; busy stays low, one per cycle.
// Distribute with pending tickets and active windows: busy through a fetch,
//   a serial min scan over the windows and an assign per ticket, then one
//   report per window; results stream out, receiver cannot stall.
// Reset: queue empty, loads zero, next ticket 1, window count 4; queue
//   memory contents are not cleared, so no clearing pass is needed.
`default_nettype none
module least_loaded_window_dispatcher (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          command,
    input  wire logic [llwd_pkg::TIME_W-1:0]   service_time,
    // result channel, one beat per cycle marked by valid
    output logic                               valid,
    output logic [1:0]                         kind,
    output logic [llwd_pkg::TICKET_W-1:0]      ticket,
    output logic [llwd_pkg::WINDOW_W-1:0]      window,
    output logic [llwd_pkg::LOAD_W-1:0]        load,
    output logic                               last,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import llwd_pkg::*;

    logic [WCFG_W-1:0] wcount_reg;
    logic [WCFG_W-1:0] wcount_next;
    logic [WCNT_W-1:0] active_windows;
    logic              cfg_write;
    logic              sel_wcount;
    llwd_cmd_t         cmd;
    llwd_status_t      status;

    // only register 0 exists; byte address bit 2 selects the register slot
    assign pready     = 1'b1;
    assign sel_wcount = (paddr[2] == 1'b0);
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = sel_wcount ? 32'(wcount_reg) : '0;

    always_comb
    begin
        wcount_next = wcount_reg;
        if (cfg_write && sel_wcount)
        begin
            wcount_next = pwdata[WCFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcount_reg <= WCOUNT_RESET;
        end
        else
        begin
            wcount_reg <= wcount_next;
        end
    end

    // clamp the programmed count: zero acts as one, above the maximum as the max
    always_comb
    begin
        if (wcount_reg == '0)
        begin
            active_windows = WCNT_W'(1);
        end
        else if (32'(wcount_reg) > MAX_WINDOWS)
        begin
            active_windows = WCNT_W'(MAX_WINDOWS);
        end
        else
        begin
            active_windows = WCNT_W'(wcount_reg);
        end
    end

    // hold the sequence in the controller, the state in the datapath
    llwd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    llwd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .service_time   (service_time),
        .active_windows (active_windows),
        .status         (status),
        .valid          (valid),
        .kind           (kind),
        .ticket         (ticket),
        .window         (window),
        .load           (load),
        .last           (last)
    );

endmodule
`default_nettype wire

[rtl/llwd_ctrl.sv]
// Sequencing state machine of the dispatcher: accepts beats and steps the
// datapath through fetch, window scan, assignment and report. Uses llwd_pkg.
`default_nettype none
module llwd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  command,
    input  wire llwd_pkg::llwd_status_t status,
    output llwd_pkg::llwd_cmd_t        cmd,
    output logic                       busy
);
    import llwd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command)
                begin
                    state_next = status.count_zero ? ST_REPORT : ST_FETCH;
                end
            end
            ST_FETCH:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN: state_next = status.last_ticket ? ST_REPORT : ST_FETCH;
            ST_REPORT:
            begin
                if (status.last_window)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.enq        = accept && !command;
                cmd.dist_start = accept && command;
            end
            ST_FETCH:  cmd.fetch      = 1'b1;
            ST_SCAN:   cmd.scan_step  = !status.scan_done;
            ST_ASSIGN: cmd.assign_tkt = 1'b1;
            ST_REPORT: cmd.report     = 1'b1;
            default:   cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/llwd_datapath.sv]
// Datapath of the dispatcher: pending ticket queue memory, ticket counter,
// window loads, serial minimum search and result registers. Uses llwd_pkg.
`default_nettype none
module llwd_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire llwd_pkg::llwd_cmd_t             cmd,
    input  wire logic [llwd_pkg::TIME_W-1:0]     service_time,
    input  wire logic [llwd_pkg::WCNT_W-1:0]     active_windows,
    output llwd_pkg::llwd_status_t               status,
    output logic                                 valid,
    output logic [1:0]                           kind,
    output logic [llwd_pkg::TICKET_W-1:0]        ticket,
    output logic [llwd_pkg::WINDOW_W-1:0]        window,
    output logic [llwd_pkg::LOAD_W-1:0]          load,
    output logic                                 last
);
    import llwd_pkg::*;

    logic [ENTRY_W-1:0] queue_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic [QADR_W-1:0]   tidx_reg,   tidx_next;
    logic [TICKET_W-1:0] tnum_reg,   tnum_next;
    logic [WCNT_W-1:0]   scan_w_reg, scan_w_next;
    logic [WIDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [LOAD_W-1:0]   best_val_reg, best_val_next;
    logic [LOAD_W-1:0]   load_reg [MAX_WINDOWS];
    logic [LOAD_W-1:0]   load_next [MAX_WINDOWS];

    logic                valid_reg,  valid_next;
    kind_t               kind_reg,   kind_next;
    logic [TICKET_W-1:0] ticket_reg, ticket_next;
    logic [WINDOW_W-1:0] window_reg, window_next;
    logic [LOAD_W-1:0]   lres_reg,   lres_next;
    logic                last_reg,   last_next;

    logic                queue_full;
    logic                wr_en;
    logic [WIDX_W-1:0]   scan_idx;
    logic [LOAD_W-1:0]   scan_load;
    logic [LOAD_W:0]     sum_wide;
    logic [LOAD_W-1:0]   sum_sat;
    logic [TIME_W-1:0]   rd_time;
    logic [TICKET_W-1:0] rd_ticket;

    assign queue_full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign wr_en      = cmd.enq && !queue_full;
    assign scan_idx   = scan_w_reg[WIDX_W-1:0];
    assign scan_load  = load_reg[scan_idx];
    assign rd_time    = rd_data_reg[ENTRY_W-1:TICKET_W];
    assign rd_ticket  = rd_data_reg[TICKET_W-1:0];
    assign sum_wide   = {1'b0, best_val_reg} + (LOAD_W + 1)'(rd_time);
    assign sum_sat    = sum_wide[LOAD_W] ? LOAD_MAX : sum_wide[LOAD_W-1:0];

    assign status.count_zero  = (count_reg == '0);
    assign status.scan_done   = (scan_w_reg == active_windows);
    assign status.last_ticket = ((QCNT_W'(tidx_reg) + QCNT_W'(1)) == count_reg);
    assign status.last_window = ((scan_w_reg + WCNT_W'(1)) == active_windows);

    // queue storage: no reset, only entries below the fill count are read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[count_reg[QADR_W-1:0]] <= {service_time, tnum_reg};
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= queue_mem[tidx_reg];
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        tidx_next     = tidx_reg;
        tnum_next     = tnum_reg;
        scan_w_next   = scan_w_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        load_next     = load_reg;
        valid_next    = 1'b0;
        kind_next     = kind_reg;
        ticket_next   = ticket_reg;
        window_next   = window_reg;
        lres_next     = lres_reg;
        last_next     = last_reg;

        if (cmd.enq)
        begin
            valid_next  = 1'b1;
            window_next = '0;
            lres_next   = '0;
            last_next   = 1'b1;
            if (queue_full)
            begin
                kind_next   = KIND_FULL;
                ticket_next = '0;
            end
            else
            begin
                kind_next   = KIND_ISSUED;
                ticket_next = tnum_reg;
                count_next  = count_reg + QCNT_W'(1);
                tnum_next   = (tnum_reg == TICKET_MAX) ? TICKET_W'(1)
                                                       : tnum_reg + TICKET_W'(1);
            end
        end

        if (cmd.dist_start)
        begin
            tidx_next   = '0;
            scan_w_next = '0;
        end

        if (cmd.fetch)
        begin
            best_idx_next = '0;
            best_val_next = load_reg[0];
            scan_w_next   = WCNT_W'(1);
        end

        if (cmd.scan_step)
        begin
            if (scan_load < best_val_reg)
            begin
                best_val_next = scan_load;
                best_idx_next = scan_idx;
            end
            scan_w_next = scan_w_reg + WCNT_W'(1);
        end

        if (cmd.assign_tkt)
        begin
            load_next[best_idx_reg] = sum_sat;
            tidx_next   = tidx_reg + QADR_W'(1);
            scan_w_next = '0;
            valid_next  = 1'b1;
            kind_next   = KIND_ASSIGN;
            ticket_next = rd_ticket;
            window_next = WINDOW_W'(best_idx_reg);
            lres_next   = sum_sat;
            last_next   = 1'b0;
        end

        if (cmd.report)
        begin
            scan_w_next = scan_w_reg + WCNT_W'(1);
            valid_next  = 1'b1;
            kind_next   = KIND_REPORT;
            ticket_next = '0;
            window_next = WINDOW_W'(scan_w_reg);
            lres_next   = scan_load;
            last_next   = status.last_window;
            if (status.last_window)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tnum_reg  <= TICKET_W'(1);
            valid_reg <= 1'b0;
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            tnum_reg  <= tnum_next;
            valid_reg <= valid_next;
            load_reg  <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tidx_reg     <= tidx_next;
        scan_w_reg   <= scan_w_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        kind_reg     <= kind_next;
        ticket_reg   <= ticket_next;
        window_reg   <= window_next;
        lres_reg     <= lres_next;
        last_reg     <= last_next;
    end

    assign valid  = valid_reg;
    assign kind   = kind_reg;
    assign ticket = ticket_reg;
    assign window = window_reg;
    assign load   = lres_reg;
    assign last   = last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("pending count above queue depth");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.enq && queue_full) |=> (valid_reg && kind_reg == KIND_FULL))
        else $error("full queue enqueue did not reject");

    a_report_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg && kind_reg == KIND_REPORT) |-> (count_reg == '0))
        else $error("queue not emptied after final report");

    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg == KIND_ASSIGN || kind_reg == KIND_REPORT))
        |-> (WCNT_W'(window_reg) < active_windows))
        else $error("window index outside active range");
`endif

endmodule
`default_nettype wire

[tb/sv/least_loaded_window_dispatcher_test.sv]
// Self-checking testbench of the least-loaded window dispatcher: directed,
// random and queue-overflow traffic checked beat by beat against a built-in
// predictor. Depends on llwd_pkg and least_loaded_window_dispatcher.
module least_loaded_window_dispatcher_test;
    import llwd_pkg::*;

    // command codes of the input item
    localparam logic CMD_ENQUEUE    = 1'b0;
    localparam logic CMD_DISTRIBUTE = 1'b1;

    // register map: window_count is register 0; register 1 does not exist
    localparam logic [2:0] ADDR_WINDOW_COUNT = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;

    // silent cycles tolerated before the run is declared hung; the longest
    // silent stretch of a correct run is a sender gap or one window scan
    localparam int STALL_LIMIT = 3000;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        kind_t                 kind;
        logic [TICKET_W-1:0]   ticket;
        logic [WINDOW_W-1:0]   window;
        logic [LOAD_W-1:0]     load;
        logic                  last;
    } beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  command;
    logic [TIME_W-1:0]     service_time;
    logic                  valid;
    logic [1:0]            kind;
    logic [TICKET_W-1:0]   ticket;
    logic [WINDOW_W-1:0]   window;
    logic [LOAD_W-1:0]     load;
    logic                  last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state: pending queue, window loads, ticket counter, register
    logic [TIME_W-1:0]     queued_time [QUEUE_DEPTH];
    logic [TICKET_W-1:0]   queued_ticket [QUEUE_DEPTH];
    int                    queued_count;
    logic [LOAD_W-1:0]     window_total [MAX_WINDOWS];
    logic [TICKET_W-1:0]   ticket_next;
    logic [WCFG_W-1:0]     window_count_reg;

    beat_t                 due_beats[$];
    int                    mismatches;
    int                    idle_pct;
    int                    silent_cycles;

    least_loaded_window_dispatcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .service_time (service_time),
        .valid        (valid),
        .kind         (kind),
        .ticket       (ticket),
        .window       (window),
        .load         (load),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Queue one expected beat at the tail.
    task automatic push_beat(input kind_t k, input logic [TICKET_W-1:0] t,
                             input logic [WINDOW_W-1:0] w,
                             input logic [LOAD_W-1:0] l, input logic lst);
        beat_t b;
        b.kind = k;
        b.ticket = t;
        b.window = w;
        b.load = l;
        b.last = lst;
        due_beats.insert(due_beats.size(), b);
    endtask

    // Work out the beats of one accepted item and advance the predictor state.
    task automatic dispatch_model(input logic cmd, input logic [TIME_W-1:0] stime);
        int                active;
        int                best;
        logic [LOAD_W:0]   sum;
        if (cmd == CMD_ENQUEUE)
        begin
            if (queued_count >= QUEUE_DEPTH)
            begin
                // full: reject, counter and queue untouched
                push_beat(KIND_FULL, '0, '0, '0, 1'b1);
            end
            else
            begin
                queued_time[queued_count] = stime;
                queued_ticket[queued_count] = ticket_next;
                queued_count++;
                push_beat(KIND_ISSUED, ticket_next, '0, '0, 1'b1);
                // ticket 0 is skipped on wrap
                ticket_next = (ticket_next == TICKET_MAX) ? TICKET_W'(1)
                                                          : ticket_next + 1'b1;
            end
        end
        else
        begin
            // a count of 0 acts as 1, anything above the maximum as the maximum
            if (window_count_reg == 0)
                active = 1;
            else if (window_count_reg > MAX_WINDOWS)
                active = MAX_WINDOWS;
            else
                active = window_count_reg;
            for (int i = 0; i < queued_count; i++)
            begin
                best = 0;
                // strict compare keeps the lowest index on a tie
                for (int w = 1; w < active; w++)
                    if (window_total[w] < window_total[best])
                        best = w;
                sum = {1'b0, window_total[best]} + queued_time[i];
                if (sum > LOAD_MAX)
                    sum = {1'b0, LOAD_MAX};
                window_total[best] = sum[LOAD_W-1:0];
                push_beat(KIND_ASSIGN, queued_ticket[i], WINDOW_W'(best),
                          window_total[best], 1'b0);
            end
            queued_count = 0;
            for (int w = 0; w < active; w++)
                push_beat(KIND_REPORT, '0, WINDOW_W'(w), window_total[w], w == active - 1);
        end
    endtask

    // Check each result beat against the oldest expectation, then predict the
    // beats of an item accepted on the same edge. Both sample pre-edge values.
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n)
        begin
            if (valid)
            begin
                if (due_beats.size() == 0)
                begin
                    report_mismatch("unexpected beat, kind", kind, 0);
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (ticket !== want.ticket)
                        report_mismatch("ticket", ticket, want.ticket);
                    if (window !== want.window)
                        report_mismatch("window", window, want.window);
                    if (load !== want.load)
                        report_mismatch("load", load, want.load);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (start && !busy)
                dispatch_model(command, service_time);
        end
    end

    // Watchdog: end the run when nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid || psel)
        begin
            silent_cycles <= 0;
        end
        else if (silent_cycles >= STALL_LIMIT)
        begin
            $display("timeout at %0t: no activity for %0d cycles", $time, silent_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            silent_cycles <= silent_cycles + 1;
        end
    end

    // Send one item: hold it until accepted, then idle a random gap. With no
    // gap, start stays high and the caller drives the next item this step.
    task automatic send_item(input logic cmd, input logic [TIME_W-1:0] stime);
        int gap;
        start <= 1'b1;
        command <= cmd;
        service_time <= stime;
        do @(posedge clk); while (busy);
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            command <= 1'($urandom);
            service_time <= TIME_W'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every expected beat is in and the block is idle.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (due_beats.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write window_count while idle, with junk in the unused data bits, and
    // read it back.
    task automatic set_window_count(input logic [WCFG_W-1:0] value);
        logic [31:0] rd;
        drain();
        apb_access(1'b1, ADDR_WINDOW_COUNT, {27'($urandom), value}, rd);
        window_count_reg = value;
        apb_access(1'b0, ADDR_WINDOW_COUNT, 32'($urandom), rd);
        if (rd[WCFG_W-1:0] !== value)
            report_mismatch("window_count readback", rd[WCFG_W-1:0], value);
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return TIME_W'($urandom_range(0, 3));   // small: many ties
            default: return TIME_W'($urandom);
        endcase
    endfunction

    function automatic logic [WCFG_W-1:0] pick_window_count();
        case ($urandom_range(0, 7))
            0:       return WCFG_W'(0);
            1:       return WCFG_W'(1);
            2:       return WCFG_W'(MAX_WINDOWS);
            3:       return WCFG_W'($urandom_range(MAX_WINDOWS + 1, 31));
            default: return WCFG_W'($urandom_range(1, MAX_WINDOWS));
        endcase
    endfunction

    // Empty distribute right after reset: only the reports of the four
    // default windows, all zero.
    task automatic test_empty_distribute();
        send_item(CMD_DISTRIBUTE, '1);
        drain();
    endtask

    // Extreme and alternating service times, spread over the default windows.
    task automatic test_extreme_times();
        send_item(CMD_ENQUEUE, '0);
        send_item(CMD_ENQUEUE, '1);
        send_item(CMD_ENQUEUE, 10'h155);
        send_item(CMD_ENQUEUE, 10'h2AA);
        send_item(CMD_ENQUEUE, '0);
        send_item(CMD_DISTRIBUTE, '0);
        drain();
    endtask

    // Window count of 0, above the maximum, and exactly the maximum; a write
    // to an unmapped address must leave the register alone.
    task automatic test_window_count_limits();
        logic [31:0] rd;
        set_window_count(WCFG_W'(0));
        send_item(CMD_ENQUEUE, 10'd7);
        send_item(CMD_ENQUEUE, 10'd3);
        send_item(CMD_DISTRIBUTE, '0);
        set_window_count(WCFG_W'(31));
        send_item(CMD_ENQUEUE, '1);
        send_item(CMD_ENQUEUE, 10'd1);
        send_item(CMD_ENQUEUE, 10'd2);
        send_item(CMD_DISTRIBUTE, '0);
        set_window_count(WCFG_W'(MAX_WINDOWS));
        drain();
        apb_access(1'b1, ADDR_UNMAPPED, 32'h1, rd);
        send_item(CMD_DISTRIBUTE, '0);
        // narrowing the range keeps the loads of the dropped windows
        set_window_count(WCFG_W'(2));
        send_item(CMD_ENQUEUE, 10'd5);
        send_item(CMD_DISTRIBUTE, '0);
        set_window_count(WCFG_W'(MAX_WINDOWS));
        send_item(CMD_DISTRIBUTE, '0);
        drain();
    endtask

    // Mostly bursts of enqueues closed by a distribute, some long enough to
    // fill the queue; the rest lone items, register changes and full drains.
    task automatic test_random_traffic(input int pct, input int items);
        int sent;
        int burst;
        idle_pct = pct;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                begin
                    burst = ($urandom_range(0, 7) == 0) ? $urandom_range(44, 52)
                                                        : $urandom_range(0, 10);
                    repeat (burst) send_item(CMD_ENQUEUE, pick_time());
                    send_item(CMD_DISTRIBUTE, TIME_W'($urandom));
                    sent += burst + 1;
                end
                14, 15, 16:
                begin
                    send_item(1'($urandom), TIME_W'($urandom));
                    sent++;
                end
                17, 18:  set_window_count(pick_window_count());
                default: drain();
            endcase
        end
        drain();
    endtask

    // Overfill the queue back to back with one window taking every ticket,
    // then spread a few more tickets over three windows.
    task automatic test_queue_overflow();
        idle_pct = 0;
        set_window_count(WCFG_W'(1));
        repeat (QUEUE_DEPTH + 2) send_item(CMD_ENQUEUE, '1);
        send_item(CMD_DISTRIBUTE, '0);
        set_window_count(WCFG_W'(3));
        repeat (4) send_item(CMD_ENQUEUE, pick_time());
        send_item(CMD_DISTRIBUTE, '0);
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_ENQUEUE;
        service_time = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        silent_cycles = 0;
        idle_pct = 35;
        queued_count = 0;
        ticket_next = TICKET_W'(1);
        window_count_reg = WCOUNT_RESET;
        for (int w = 0; w < MAX_WINDOWS; w++)
            window_total[w] = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            queued_time[i] = '0;
            queued_ticket[i] = '0;
        end

        // hold reset low, then release it at a clock edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_distribute();
        test_extreme_times();
        test_window_count_limits();
        test_random_traffic(35, 85);
        test_random_traffic(78, 85);
        test_random_traffic(0, 85);
        test_queue_overflow();

        drain();
        if (due_beats.size() != 0)
            report_mismatch("beats never delivered", due_beats.size(), 0);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
